// ===== src/cfe_pkg.sv =====
// Shared types and constants for the CRC-32 frame encoder.
// Holds the item structs, job format, step codes and the CRC byte update.
// No dependencies.
package cfe_pkg;

	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
	localparam logic [31:0] CRC_ONES  = 32'hFFFF_FFFF;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAGIC_FIRST  = 2'd0,
		CFG_MAGIC_SECOND = 2'd1,
		CFG_VERSION      = 2'd2
	} cfg_idx_t;

	// Input op codes
	typedef enum logic {
		OP_START = 1'b0,
		OP_DATA  = 1'b1
	} op_t;

	// Byte positions walked by the back end
	typedef logic [3:0] step_t;
	localparam step_t STEP_MAGIC0  = 4'd0;
	localparam step_t STEP_MAGIC1  = 4'd1;
	localparam step_t STEP_VERSION = 4'd2;
	localparam step_t STEP_TYPE    = 4'd3;
	localparam step_t STEP_SEQ0    = 4'd4;
	localparam step_t STEP_SEQ1    = 4'd5;
	localparam step_t STEP_SEQ2    = 4'd6;
	localparam step_t STEP_SEQ3    = 4'd7;
	localparam step_t STEP_LEN0    = 4'd8;
	localparam step_t STEP_HDR_END = 4'd9;
	localparam step_t STEP_PAYLOAD = 4'd10;
	localparam step_t STEP_CRC0    = 4'd11;
	localparam step_t STEP_CRC1    = 4'd12;
	localparam step_t STEP_CRC2    = 4'd13;
	localparam step_t STEP_LAST    = 4'd14;

	typedef struct packed {
		logic        op;
		logic [7:0]  packet_type;
		logic [31:0] sequence_req;
		logic [15:0] payload_length;
		logic [7:0]  payload_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_end;
		logic       run_last;
	} out_item_t;

	typedef struct packed {
		logic [7:0] magic_first;
		logic [7:0] magic_second;
		logic [7:0] protocol_version;
	} cfg_t;

	// One unit of work for the back end
	typedef struct packed {
		op_t         kind;
		logic        trailer;   // append the CRC after this job's bytes
		logic [7:0]  packet_type;
		logic [31:0] sequence_req;
		logic [15:0] payload_length;
		logic [7:0]  payload_byte;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// Reflected CRC-32 update by one byte
	function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== src/crc32_frame_encoder_top.sv =====
// Top level of the CRC-32 frame encoder.
// Depends on cfe_pkg, cfe_front, cfe_queue and cfe_back.
//
// Usage:
//   in_valid/in_ready/in_data carry input items. A start item (op = 0)
//   produces a 10-byte header (magic, magic, version, type, sequence LE,
//   length LE); each data item (op = 1) produces one payload byte. After
//   the last payload byte, or right after the header for an empty frame,
//   the CRC-32 (IEEE, reflected) is appended LSB first.
//   out_valid/out_ready/out_data carry one frame byte per transfer, with
//   frame_end on the last CRC byte and run_last on the last byte of each item.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the magic and version
//   registers while no item is in flight; cfg_ready is always high.
// Timing:
//   An item's first output byte is registered in the job queue, then in the
//   output register. The output side moves one byte per clock while the
//   receiver is ready. The job queue (QUEUE_DEPTH entries) absorbs header and
//   trailer runs, so payload streams at one item per clock while the receiver
//   is ready. A stalled receiver holds the output register; in_ready drops
//   only when the queue is full. Reset empties the queue, closes any frame
//   and clears the configuration registers to zero.
module crc32_frame_encoder_top #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  cfe_pkg::in_item_t               in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output cfe_pkg::out_item_t              out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cfe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [7:0]                      cfg_data
);
	import cfe_pkg::*;

	cfg_t    cfg_q;
	q_stat_t q_stat;
	job_t    push_job, head;
	logic    push, pop;

	// configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MAGIC_FIRST:  cfg_q.magic_first      <= cfg_data;
				CFG_MAGIC_SECOND: cfg_q.magic_second     <= cfg_data;
				CFG_VERSION:      cfg_q.protocol_version <= cfg_data;
				default:          ;
			endcase
		end
	end

	// front end: classification and frame tracking
	cfe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_stat   (q_stat),
		.push     (push),
		.job      (push_job)
	);

	// decoupling queue
	cfe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	// back end: byte sequencing, CRC, output register
	cfe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// frame end is always the last byte of its item
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!out_data.frame_end || out_data.run_last))
		else $error("frame_end without run_last");

	// queue is never written while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_stat.full))
		else $error("job queue overflow");

	// queue is never read while empty
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && q_stat.empty))
		else $error("job queue underflow");

	// a pushed job shows up as queue occupancy on the next cycle
	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> !q_stat.empty)
		else $error("pushed job lost");

endmodule

// ===== src/cfe_front.sv =====
// Front end: takes input transfers, tracks the open frame and queues jobs.
// Depends on cfe_pkg.
module cfe_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  cfe_pkg::in_item_t in_data,
	input  cfe_pkg::q_stat_t  q_stat,
	output logic              push,
	output cfe_pkg::job_t     job
);
	import cfe_pkg::*;

	logic [15:0] remaining_q;   // nonzero means a frame is open
	logic        accept;

	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		job.kind           = op_t'(in_data.op);
		job.packet_type    = in_data.packet_type;
		job.sequence_req   = in_data.sequence_req;
		job.payload_length = in_data.payload_length;
		job.payload_byte   = in_data.payload_byte;
		if (in_data.op == OP_START) begin
			job.trailer = (in_data.payload_length == 16'd0);
		end else begin
			job.trailer = (remaining_q == 16'd1);
		end
		// data with no open frame is dropped
		push = accept && ((in_data.op == OP_START) || (remaining_q != 16'd0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remaining_q <= 16'd0;
		end else if (accept) begin
			if (in_data.op == OP_START) begin
				remaining_q <= in_data.payload_length;
			end else if (remaining_q != 16'd0) begin
				remaining_q <= remaining_q - 16'd1;
			end
		end
	end

endmodule

// ===== src/cfe_queue.sv =====
// Small job queue between the front and back ends.
// Depends on cfe_pkg.
module cfe_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  cfe_pkg::job_t     push_job,
	input  logic              pop,
	output cfe_pkg::job_t     head,
	output cfe_pkg::q_stat_t  stat
);
	import cfe_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	job_t             mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head       = mem[rd_ptr_q];
	assign stat.full  = (count_q == CNT_FULL);
	assign stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/cfe_back.sv =====
// Back end: walks each queued job byte by byte, runs the CRC and drives
// the output register. Depends on cfe_pkg.
module cfe_back (
	input  logic               clk,
	input  logic               arst_n,
	input  cfe_pkg::cfg_t      cfg,
	input  cfe_pkg::job_t      head,
	input  cfe_pkg::q_stat_t   q_stat,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output cfe_pkg::out_item_t out_data
);
	import cfe_pkg::*;

	logic        mid_q;       // a job is partly emitted
	step_t       step_q;
	logic [31:0] crc_q;
	out_item_t   out_q;
	logic        out_valid_q;

	step_t       step, step_nxt;
	logic        emit, done;
	logic [7:0]  b;
	logic [31:0] crc_base, crc_post;

	always_comb begin
		if (mid_q) begin
			step = step_q;
		end else begin
			step = (head.kind == OP_START) ? STEP_MAGIC0 : STEP_PAYLOAD;
		end

		emit = !q_stat.empty && (!out_valid_q || out_ready);

		unique case (step)
			STEP_MAGIC0:  b = cfg.magic_first;
			STEP_MAGIC1:  b = cfg.magic_second;
			STEP_VERSION: b = cfg.protocol_version;
			STEP_TYPE:    b = head.packet_type;
			STEP_SEQ0:    b = head.sequence_req[7:0];
			STEP_SEQ1:    b = head.sequence_req[15:8];
			STEP_SEQ2:    b = head.sequence_req[23:16];
			STEP_SEQ3:    b = head.sequence_req[31:24];
			STEP_LEN0:    b = head.payload_length[7:0];
			STEP_HDR_END: b = head.payload_length[15:8];
			STEP_PAYLOAD: b = head.payload_byte;
			STEP_CRC0:    b = ~crc_q[7:0];
			STEP_CRC1:    b = ~crc_q[15:8];
			STEP_CRC2:    b = ~crc_q[23:16];
			STEP_LAST:    b = ~crc_q[31:24];
			default:      b = 8'd0;
		endcase

		crc_base = (step == STEP_MAGIC0) ? CRC_ONES : crc_q;
		crc_post = crc_feed(crc_base, b);

		done = (step == STEP_LAST) ||
			(((step == STEP_HDR_END) || (step == STEP_PAYLOAD)) && !head.trailer);
		// empty payload: header runs straight into the trailer
		step_nxt = ((step == STEP_HDR_END) && head.trailer) ? STEP_CRC0 : step + 4'd1;

		pop = emit && done;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.out_byte  <= b;
			out_q.frame_end <= (step == STEP_LAST);
			out_q.run_last  <= done;
			if (step <= STEP_PAYLOAD) begin
				crc_q <= crc_post;
			end
			step_q <= step_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (emit) begin
			mid_q       <= !done;
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
